FILE: src/random_permutation_shuffler_assert.svh
// Assertion macros shared by the shuffler RTL.
// No dependencies; each file that checks its own logic includes this header.
`ifndef RANDOM_PERMUTATION_SHUFFLER_ASSERT_SVH
`define RANDOM_PERMUTATION_SHUFFLER_ASSERT_SVH

// Same-cycle implication.
`define RPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rps_pkg.sv
// Shared types and constants for the random permutation shuffler.
// No dependencies.
package rps_pkg;

   localparam int WORD_W     = 31;
   localparam int STEP_W     = $clog2(WORD_W);
   localparam int VAL_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_METHOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 2'd1;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_STEP = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_LOADED   = 3'd0,
      ST_SWAPPED  = 3'd1,
      ST_REJECTED = 3'd2,
      ST_COMPLETE = 3'd3,
      ST_READ     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_DIV,
      S_EVAL,
      S_RD_B,
      S_WR_A,
      S_WR_B,
      S_READ,
      S_READ_CAP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

FILE: src/rps_store.sv
// Permutation store: single-port-write, single-port-read RAM, registered read.
// Depends on rps_pkg for the entry width.
module rps_store #(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [rps_pkg::VAL_W-1:0]    wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [rps_pkg::VAL_W-1:0]    rd_data
);

   logic [rps_pkg::VAL_W-1:0] mem [DEPTH];
   logic [rps_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rps_mod_unit.sv
// Two-lane restoring remainder unit: one quotient bit per cycle per lane.
// Both lanes share the divisor. Depends on rps_pkg.
module rps_mod_unit #(
   parameter int DIV_W = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rps_pkg::WORD_W-1:0]    dividend_a,
   input  logic [rps_pkg::WORD_W-1:0]    dividend_b,
   input  logic [DIV_W-1:0]              divisor,
   output rps_pkg::mod_status_type       status,
   output logic [DIV_W-1:0]              rem_a,
   output logic [DIV_W-1:0]              rem_b
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rps_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [rps_pkg::WORD_W-1:0]    sh_a_ff, sh_a_in;
   logic [rps_pkg::WORD_W-1:0]    sh_b_ff, sh_b_in;
   logic [DIV_W-1:0]              rem_a_ff, rem_a_in;
   logic [DIV_W-1:0]              rem_b_ff, rem_b_in;
   logic [DIV_W-1:0]              div_ff, div_in;
   logic [DIV_W:0]                trial_a, trial_b;
   logic [DIV_W-1:0]              nrem_a, nrem_b;

   // trial stays below twice the divisor, so one compare and subtract suffices
   always_comb begin
      trial_a = {rem_a_ff, sh_a_ff[rps_pkg::WORD_W-1]};
      trial_b = {rem_b_ff, sh_b_ff[rps_pkg::WORD_W-1]};
      if (trial_a >= {1'b0, div_ff}) begin
         nrem_a = DIV_W'(trial_a - {1'b0, div_ff});
      end else begin
         nrem_a = DIV_W'(trial_a);
      end
      if (trial_b >= {1'b0, div_ff}) begin
         nrem_b = DIV_W'(trial_b - {1'b0, div_ff});
      end else begin
         nrem_b = DIV_W'(trial_b);
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      sh_a_in  = sh_a_ff;
      sh_b_in  = sh_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         step_in  = rps_pkg::STEP_W'(rps_pkg::WORD_W - 1);
         sh_a_in  = dividend_a;
         sh_b_in  = dividend_b;
         rem_a_in = '0;
         rem_b_in = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_a_in = nrem_a;
         rem_b_in = nrem_b;
         sh_a_in  = {sh_a_ff[rps_pkg::WORD_W-2:0], 1'b0};
         sh_b_in  = {sh_b_ff[rps_pkg::WORD_W-2:0], 1'b0};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      sh_a_ff  <= sh_a_in;
      sh_b_ff  <= sh_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      div_ff   <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign rem_a       = rem_a_ff;
   assign rem_b       = rem_b_ff;

endmodule

FILE: src/random_permutation_shuffler.sv
// Fisher-Yates / naive shuffler; state in rps_store, remainders from rps_mod_unit, rps_pkg.
// Result registered after a load has written count entries, after a read, after a step past
// the end, after a rejected word (31-bit remainder loop) and after a swap (the loop, two reads
// and two writes of the store). The next item is taken only once the block is idle again
// after the result is registered. Synchronous reset clears control state, position and the
// loaded flag; store contents stay undefined until a load writes them (no clearing pass).
`include "random_permutation_shuffler_assert.svh"

module random_permutation_shuffler #(
   parameter int PERM_SIZE  = 256,
   parameter int RANDOM_MAX = 2147483647
) (
   input  logic                              clock,
   input  logic                              reset,
   // item channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [rps_pkg::WORD_W-1:0]        req_random_word,
   input  logic [7:0]                        req_read_index,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [rps_pkg::VAL_W-1:0]         rsp_element_value,
   output logic [7:0]                        rsp_partner_index,
   output logic                              rsp_shuffle_done,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rps_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW = $clog2(PERM_SIZE);
   localparam int CW = $clog2(PERM_SIZE + 1);
   localparam int XW = (CW > rps_pkg::CSR_DATA_W) ? CW : rps_pkg::CSR_DATA_W;
   localparam logic [rps_pkg::WORD_W-1:0] RM_WORD = rps_pkg::WORD_W'(RANDOM_MAX);

   rps_pkg::state_type            state_ff, state_in;
   logic [1:0]                    cmd_ff, cmd_in;
   logic [rps_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [7:0]                    ridx_ff, ridx_in;
   logic                          method_ff, method_in;
   logic [rps_pkg::CSR_DATA_W-1:0] item_count_ff, item_count_in;
   logic [CW-1:0]                 pos_ff, pos_in;
   logic                          loaded_ff, loaded_in;
   logic [CW-1:0]                 ld_ff, ld_in;
   logic [CW-1:0]                 part_ff, part_in;
   logic [rps_pkg::VAL_W-1:0]     a_ff, a_in;
   rps_pkg::status_type           res_status_ff, res_status_in;
   logic [rps_pkg::VAL_W-1:0]     res_value_ff, res_value_in;
   logic [7:0]                    res_partner_ff, res_partner_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [2:0]                    rsp_status_ff, rsp_status_in;
   logic [rps_pkg::VAL_W-1:0]     rsp_element_value_ff, rsp_element_value_in;
   logic [7:0]                    rsp_partner_index_ff, rsp_partner_index_in;
   logic                          rsp_shuffle_done_ff, rsp_shuffle_done_in;

   logic                          req_xfer;
   logic                          csr_xfer;
   logic                          rsp_slot_free;
   logic [XW-1:0]                 count_wide;
   logic [CW-1:0]                 count;
   logic                          step_ok;
   logic [CW-1:0]                 modulus;
   logic [CW-1:0]                 partner_calc;
   logic [rps_pkg::WORD_W-1:0]    limit;
   logic                          reject;
   logic                          read_in_range;

   logic                          mem_wr_en;
   logic [AW-1:0]                 mem_wr_addr;
   logic [rps_pkg::VAL_W-1:0]     mem_wr_data;
   logic                          mem_rd_en;
   logic [AW-1:0]                 mem_rd_addr;
   logic [rps_pkg::VAL_W-1:0]     mem_rd_data;

   logic                          div_start;
   rps_pkg::mod_status_type       mod_status;
   logic [CW-1:0]                 rem_word;
   logic [CW-1:0]                 rem_max;

   rps_store #(
      .DEPTH (PERM_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rps_mod_unit #(
      .DIV_W (CW)
   ) u_mod (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_a (word_ff),
      .dividend_b (RM_WORD),
      .divisor    (modulus),
      .status     (mod_status),
      .rem_a      (rem_word),
      .rem_b      (rem_max)
   );

   assign req_ready     = (state_ff == rps_pkg::S_IDLE);
   assign csr_ready     = 1'b1;
   assign req_xfer      = req_valid & req_ready;
   assign csr_xfer      = csr_valid & csr_ready;
   assign rsp_slot_free = ~rsp_valid_ff | rsp_ready;

   // effective count: item_count clamped to 1..PERM_SIZE
   always_comb begin
      count_wide = XW'(item_count_ff);
      if (count_wide == '0) begin
         count_wide = XW'(1);
      end else if (count_wide > XW'(PERM_SIZE)) begin
         count_wide = XW'(PERM_SIZE);
      end
      count = CW'(count_wide);
   end

   assign step_ok      = loaded_ff & (pos_ff < count);
   assign modulus      = method_ff ? (count - pos_ff) : count;
   assign partner_calc = method_ff ? (pos_ff + rem_word) : rem_word;
   assign limit        = RM_WORD - rps_pkg::WORD_W'(rem_max);
   assign reject       = (word_ff >= limit);
   assign read_in_range = (32'(ridx_ff) < 32'(PERM_SIZE));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rps_pkg::S_IDLE: begin
            if (req_xfer) begin
               case (req_command)
                  rps_pkg::CMD_LOAD: state_in = rps_pkg::S_LOAD;
                  rps_pkg::CMD_STEP: state_in = rps_pkg::S_CHECK;
                  rps_pkg::CMD_READ: state_in = rps_pkg::S_READ;
                  default:           state_in = rps_pkg::S_IDLE;
               endcase
            end
         end
         rps_pkg::S_LOAD: begin
            if (ld_ff == count - 1'b1) begin
               state_in = rps_pkg::S_RESP;
            end
         end
         rps_pkg::S_CHECK: begin
            state_in = step_ok ? rps_pkg::S_DIV : rps_pkg::S_RESP;
         end
         rps_pkg::S_DIV: begin
            if (mod_status.done) begin
               state_in = rps_pkg::S_EVAL;
            end
         end
         rps_pkg::S_EVAL: begin
            state_in = reject ? rps_pkg::S_RESP : rps_pkg::S_RD_B;
         end
         rps_pkg::S_RD_B:     state_in = rps_pkg::S_WR_A;
         rps_pkg::S_WR_A:     state_in = rps_pkg::S_WR_B;
         rps_pkg::S_WR_B:     state_in = rps_pkg::S_RESP;
         rps_pkg::S_READ:     state_in = rps_pkg::S_READ_CAP;
         rps_pkg::S_READ_CAP: state_in = rps_pkg::S_RESP;
         rps_pkg::S_RESP: begin
            if (rsp_slot_free) begin
               state_in = rps_pkg::S_IDLE;
            end
         end
         default: state_in = rps_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmd_in         = cmd_ff;
      word_in        = word_ff;
      ridx_in        = ridx_ff;
      method_in      = method_ff;
      item_count_in  = item_count_ff;
      pos_in         = pos_ff;
      loaded_in      = loaded_ff;
      ld_in          = ld_ff;
      part_in        = part_ff;
      a_in           = a_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      res_partner_in = res_partner_ff;
      rsp_valid_in         = rsp_valid_ff & ~rsp_ready;
      rsp_status_in        = rsp_status_ff;
      rsp_element_value_in = rsp_element_value_ff;
      rsp_partner_index_in = rsp_partner_index_ff;
      rsp_shuffle_done_in  = rsp_shuffle_done_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(ld_ff);
      mem_wr_data = rps_pkg::VAL_W'(ld_ff);
      mem_rd_en   = 1'b0;
      mem_rd_addr = AW'(pos_ff);
      div_start   = 1'b0;

      if (csr_xfer) begin
         case (csr_index)
            rps_pkg::CSR_METHOD: method_in     = csr_data[0];
            rps_pkg::CSR_COUNT:  item_count_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         rps_pkg::S_IDLE: begin
            if (req_xfer) begin
               cmd_in  = req_command;
               word_in = req_random_word;
               ridx_in = req_read_index;
               ld_in   = '0;
            end
         end
         rps_pkg::S_LOAD: begin
            mem_wr_en = 1'b1;
            ld_in     = ld_ff + 1'b1;
            if (ld_ff == count - 1'b1) begin
               pos_in         = '0;
               loaded_in      = 1'b1;
               res_status_in  = rps_pkg::ST_LOADED;
               res_value_in   = '0;
               res_partner_in = '0;
            end
         end
         rps_pkg::S_CHECK: begin
            if (step_ok) begin
               div_start = 1'b1;
            end else begin
               res_status_in  = rps_pkg::ST_COMPLETE;
               res_value_in   = '0;
               res_partner_in = '0;
            end
         end
         rps_pkg::S_EVAL: begin
            if (reject) begin
               res_status_in  = rps_pkg::ST_REJECTED;
               res_value_in   = '0;
               res_partner_in = '0;
            end else begin
               part_in   = partner_calc;
               mem_rd_en = 1'b1;
            end
         end
         rps_pkg::S_RD_B: begin
            a_in        = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(part_ff);
         end
         rps_pkg::S_WR_A: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(pos_ff);
            mem_wr_data = mem_rd_data;
         end
         rps_pkg::S_WR_B: begin
            mem_wr_en      = 1'b1;
            mem_wr_addr    = AW'(part_ff);
            mem_wr_data    = a_ff;
            pos_in         = pos_ff + 1'b1;
            res_status_in  = rps_pkg::ST_SWAPPED;
            res_value_in   = '0;
            res_partner_in = 8'(part_ff);
         end
         rps_pkg::S_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(ridx_ff);
         end
         rps_pkg::S_READ_CAP: begin
            res_status_in  = rps_pkg::ST_READ;
            res_value_in   = read_in_range ? mem_rd_data : '0;
            res_partner_in = '0;
         end
         rps_pkg::S_RESP: begin
            if (rsp_slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_status_in        = res_status_ff;
               rsp_element_value_in = res_value_ff;
               rsp_partner_index_in = res_partner_ff;
               rsp_shuffle_done_in  = loaded_ff & (pos_ff >= count);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rps_pkg::S_IDLE;
         method_ff     <= 1'b1;
         item_count_ff <= rps_pkg::CSR_DATA_W'(256);
         pos_ff        <= '0;
         loaded_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         method_ff     <= method_in;
         item_count_ff <= item_count_in;
         pos_ff        <= pos_in;
         loaded_ff     <= loaded_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff               <= cmd_in;
      word_ff              <= word_in;
      ridx_ff              <= ridx_in;
      ld_ff                <= ld_in;
      part_ff              <= part_in;
      a_ff                 <= a_in;
      res_status_ff        <= res_status_in;
      res_value_ff         <= res_value_in;
      res_partner_ff       <= res_partner_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_element_value_ff <= rsp_element_value_in;
      rsp_partner_index_ff <= rsp_partner_index_in;
      rsp_shuffle_done_ff  <= rsp_shuffle_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_value = rsp_element_value_ff;
   assign rsp_partner_index = rsp_partner_index_ff;
   assign rsp_shuffle_done  = rsp_shuffle_done_ff;

   // sequencing of the step path, the store and the remainder unit
   `RPS_ASSERT_IMP(a_cmd_step, clock, reset, (state_ff == rps_pkg::S_CHECK), (cmd_ff == rps_pkg::CMD_STEP), "step path entered without a step command")
   `RPS_ASSERT_IMP(a_wr_state, clock, reset, mem_wr_en, (state_ff == rps_pkg::S_LOAD || state_ff == rps_pkg::S_WR_A || state_ff == rps_pkg::S_WR_B), "store written outside load or swap")
   `RPS_ASSERT_IMP(a_load_range, clock, reset, (state_ff == rps_pkg::S_LOAD), (ld_ff < count), "load sweep ran past count")
   `RPS_ASSERT_NXT(a_div_done, clock, reset, (state_ff == rps_pkg::S_DIV && mod_status.done), (state_ff == rps_pkg::S_EVAL), "remainder ready but no evaluation")
   `RPS_ASSERT_NXT(a_swap_adv, clock, reset, (state_ff == rps_pkg::S_WR_B), (pos_ff == $past(pos_ff) + 1'b1), "position did not advance after swap")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for random_permutation_shuffler: directed rows, a back-pressure run, then random shuffle runs.
// Depends on rps_pkg and the shuffler RTL; outcomes are computed in-bench per accepted item or written by hand.

module testbench;

   localparam int unsigned RAND_TOP       = 2147483647;
   localparam int unsigned STORE_DEPTH    = 256;
   localparam int unsigned SETTLE_CYCLES  = 50;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned ITEMS_PER_MODE = 150;

   typedef struct packed {
      rps_pkg::status_type status;
      logic [7:0]          value;
      logic [7:0]          partner;
      logic                done;
   } shuffle_rsp_type;

   typedef struct {
      bit                is_csr;
      logic [1:0]        csr_idx;
      logic [8:0]        csr_val;
      rps_pkg::cmd_type  cmd;
      logic [30:0]       word;
      logic [7:0]        idx;
      bit                typed;
      shuffle_rsp_type   rsp;
   } plan_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [1:0]    req_command = 2'd0;
   logic [30:0]   req_random_word = '0;
   logic [7:0]    req_read_index = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [2:0]    rsp_status;
   logic [7:0]    rsp_element_value;
   logic [7:0]    rsp_partner_index;
   logic          rsp_shuffle_done;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [8:0]    csr_data = '0;

   // shadow of the block's state and registers
   logic [7:0]    perm_entries [STORE_DEPTH];
   int unsigned   step_pos = 0;
   bit            is_loaded = 1'b0;
   logic          method_reg = 1'b1;
   logic [8:0]    count_reg = 9'd256;
   int unsigned   hi_water = 0;       // entries below this have been written by a load

   shuffle_rsp_type awaited_outcomes [$];
   plan_row_type    dir_rows [$];

   int unsigned   send_idle_pct = 0;
   int unsigned   stall_pct = 0;
   bit            hold_req = 1'b0;
   int unsigned   hold_left = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   errors = 0;
   int unsigned   results_sent = 0;
   int unsigned   results_seen = 0;
   int unsigned   swaps_seen = 0;
   int unsigned   rejects_seen = 0;
   int unsigned   csr_writes = 0;

   random_permutation_shuffler i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_random_word   (req_random_word),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_partner_index (rsp_partner_index),
      .rsp_shuffle_done  (rsp_shuffle_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_count(input logic [8:0] raw);
      if (raw < 1) return 1;
      if (raw > STORE_DEPTH) return STORE_DEPTH;
      return raw;
   endfunction

   // Applies one command to the shadow state; returns 0 for the ignored command.
   function automatic bit compute_outcome(input rps_pkg::cmd_type cmd, input logic [30:0] word,
                                          input logic [7:0] idx, output shuffle_rsp_type rsp);
      int unsigned cnt, m, lim, r, p, i;
      logic [7:0]  t;
      cnt = clamp_count(count_reg);
      rsp.status  = rps_pkg::ST_LOADED;
      rsp.value   = '0;
      rsp.partner = '0;
      rsp.done    = 1'b0;
      case (cmd)
         rps_pkg::CMD_LOAD: begin
            for (i = 0; i < cnt; i++) perm_entries[i] = i[7:0];
            step_pos  = 0;
            is_loaded = 1'b1;
            if (cnt > hi_water) hi_water = cnt;
         end
         rps_pkg::CMD_STEP: begin
            if (!is_loaded || step_pos >= cnt) begin
               rsp.status = rps_pkg::ST_COMPLETE;
            end else begin
               m   = method_reg ? cnt - step_pos : cnt;
               lim = RAND_TOP - (RAND_TOP % m);
               if (word >= lim) begin
                  rsp.status = rps_pkg::ST_REJECTED;
               end else begin
                  r = word % m;
                  p = method_reg ? step_pos + r : r;
                  if (p >= cnt) p = cnt - 1;
                  t = perm_entries[step_pos];
                  perm_entries[step_pos] = perm_entries[p];
                  perm_entries[p] = t;
                  step_pos++;
                  rsp.status  = rps_pkg::ST_SWAPPED;
                  rsp.partner = p[7:0];
               end
            end
         end
         rps_pkg::CMD_READ: begin
            rsp.status = rps_pkg::ST_READ;
            rsp.value  = perm_entries[idx];
         end
         default: return 1'b0;
      endcase
      rsp.done = is_loaded && (step_pos >= cnt);
      return 1'b1;
   endfunction

   function automatic plan_row_type item_row(input rps_pkg::cmd_type cmd,
                                             input logic [30:0] word, input logic [7:0] idx);
      plan_row_type row;
      row.is_csr  = 1'b0;
      row.csr_idx = '0;
      row.csr_val = '0;
      row.cmd     = cmd;
      row.word    = word;
      row.idx     = idx;
      row.typed   = 1'b0;
      row.rsp     = '0;
      return row;
   endfunction

   // Row whose outcome is written out by hand (partner is zero in all of these).
   function automatic plan_row_type fixed_row(input rps_pkg::cmd_type cmd,
                                              input logic [30:0] word, input logic [7:0] idx,
                                              input rps_pkg::status_type st,
                                              input logic [7:0] val, input logic done);
      plan_row_type row;
      row = item_row(cmd, word, idx);
      row.typed       = 1'b1;
      row.rsp.status  = st;
      row.rsp.value   = val;
      row.rsp.partner = '0;
      row.rsp.done    = done;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] index, input logic [8:0] data);
      plan_row_type row;
      row = item_row(rps_pkg::CMD_NONE, '0, '0);
      row.is_csr  = 1'b1;
      row.csr_idx = index;
      row.csr_val = data;
      return row;
   endfunction

   function automatic logic [30:0] pick_word();
      if ($urandom_range(0, 99) < 8) return 31'(RAND_TOP - $urandom_range(0, 300));
      return 31'($urandom);
   endfunction

   function automatic logic [8:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 9'($urandom_range(1, 6));
      if (roll < 80) return 9'($urandom_range(7, 24));
      if (roll < 90) return 9'($urandom_range(25, 64));
      if (roll < 95) return 9'd256;
      case ($urandom_range(0, 3))
         0: return 9'd0;
         1: return 9'd257;
         2: return 9'd511;
         default: return 9'd256;
      endcase
   endfunction

   task automatic send_item(input rps_pkg::cmd_type cmd, input logic [30:0] word,
                            input logic [7:0] idx, input bit typed,
                            input shuffle_rsp_type typed_rsp);
      shuffle_rsp_type outcome;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_random_word <= word;
      req_read_index  <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (compute_outcome(cmd, word, idx, outcome)) begin
         awaited_outcomes.push_back(typed ? typed_rsp : outcome);
         results_sent++;
      end
   endtask

   task automatic send_random(input rps_pkg::cmd_type cmd, input logic [30:0] word);
      send_item(cmd, word, 8'($urandom), 1'b0, '0);
   endtask

   task automatic send_read();
      send_item(rps_pkg::CMD_READ, 31'($urandom), 8'($urandom_range(0, hi_water - 1)),
                1'b0, '0);
   endtask

   // Registers only change with nothing in flight; the pause covers an ignored command.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == rps_pkg::CSR_METHOD) method_reg = data[0];
      else if (index == rps_pkg::CSR_COUNT) count_reg = data;
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // New settings, usually a fresh load, then steps mixed with reads and noise.
   task automatic run_shuffle_sequence();
      int unsigned eff, n, k, roll;
      wait_for_idle();
      write_csr(rps_pkg::CSR_METHOD, 9'($urandom_range(0, 1)));
      write_csr(rps_pkg::CSR_COUNT, pick_count());
      eff = clamp_count(count_reg);
      if ($urandom_range(0, 9) != 0 || eff > hi_water) begin
         send_random(rps_pkg::CMD_LOAD, pick_word());
      end
      n = eff + $urandom_range(2, 8);
      if (n > 40) n = 40;
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) send_random(rps_pkg::CMD_STEP, pick_word());
         else if (roll < 85) send_read();
         else if (roll < 90) send_random(rps_pkg::CMD_NONE, 31'($urandom));
         else if (roll < 95) send_random(rps_pkg::CMD_LOAD, 31'($urandom));
         else send_random(rps_pkg::CMD_STEP, 31'(RAND_TOP));
      end
   endtask

   // result channel ready, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      shuffle_rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_seen++;
         if (awaited_outcomes.size() == 0) begin
            $error("result transfer with nothing outstanding: status %0d", rsp_status);
            errors++;
         end else begin
            exp_rsp = awaited_outcomes.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
               errors++;
            end
            if (rsp_element_value !== exp_rsp.value) begin
               $error("element_value: expected %0d, got %0d", exp_rsp.value, rsp_element_value);
               errors++;
            end
            if (rsp_partner_index !== exp_rsp.partner) begin
               $error("partner_index: expected %0d, got %0d", exp_rsp.partner,
                      rsp_partner_index);
               errors++;
            end
            if (rsp_shuffle_done !== exp_rsp.done) begin
               $error("shuffle_done: expected %0d, got %0d", exp_rsp.done, rsp_shuffle_done);
               errors++;
            end
            if (exp_rsp.status == rps_pkg::ST_SWAPPED) swaps_seen++;
            if (exp_rsp.status == rps_pkg::ST_REJECTED) rejects_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, awaited_outcomes.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned  mode, k, mark;
      int unsigned  mode_send [4];
      int unsigned  mode_stall [4];
      plan_row_type row;
      mode_send  = '{0, 76, 0, 19};
      mode_stall = '{0, 0, 76, 19};

      // directed rows start from reset settings: Durstenfeld, 256 entries
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'd0, 8'd0, rps_pkg::ST_COMPLETE,
                                   8'd0, 1'b0));
      dir_rows.push_back(item_row(rps_pkg::CMD_NONE, 31'h7FFF_FFFF, 8'hFF));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_LOAD, 31'd0, 8'd0, rps_pkg::ST_LOADED,
                                   8'd0, 1'b0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_READ, 31'd0, 8'd255, rps_pkg::ST_READ,
                                   8'd255, 1'b0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_READ, 31'h7FFF_FFFF, 8'd0, rps_pkg::ST_READ,
                                   8'd0, 1'b0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'(RAND_TOP), 8'd0,
                                   rps_pkg::ST_REJECTED, 8'd0, 1'b0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'd0, 8'd0, rps_pkg::ST_SWAPPED,
                                   8'd0, 1'b0));
      dir_rows.push_back(item_row(rps_pkg::CMD_STEP, 31'(RAND_TOP - 200), 8'd0));
      dir_rows.push_back(item_row(rps_pkg::CMD_STEP, 31'h5555_5555, 8'h55));
      dir_rows.push_back(item_row(rps_pkg::CMD_READ, 31'd0, 8'hAA));
      // method switched part-way through a shuffle
      dir_rows.push_back(csr_row(rps_pkg::CSR_METHOD, 9'd0));
      dir_rows.push_back(item_row(rps_pkg::CMD_STEP, 31'h2AAA_AAAA, 8'd0));
      dir_rows.push_back(item_row(rps_pkg::CMD_READ, 31'd0, 8'd1));
      // count of zero clamps to one, already past the end
      dir_rows.push_back(csr_row(rps_pkg::CSR_COUNT, 9'd0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'd5, 8'd0, rps_pkg::ST_COMPLETE,
                                   8'd0, 1'b1));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'd0, 8'd0, rps_pkg::ST_COMPLETE,
                                   8'd0, 1'b1));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_LOAD, 31'd0, 8'd0, rps_pkg::ST_LOADED,
                                   8'd0, 1'b0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'(RAND_TOP), 8'd0,
                                   rps_pkg::ST_REJECTED, 8'd0, 1'b0));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_STEP, 31'(RAND_TOP - 1), 8'd0,
                                   rps_pkg::ST_SWAPPED, 8'd0, 1'b1));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_READ, 31'd0, 8'd0, rps_pkg::ST_READ,
                                   8'd0, 1'b1));
      // oversized count clamps to the store depth, shuffle resumes
      dir_rows.push_back(csr_row(rps_pkg::CSR_COUNT, 9'd511));
      dir_rows.push_back(item_row(rps_pkg::CMD_STEP, 31'h7FFF_FEFF, 8'd0));
      dir_rows.push_back(csr_row(rps_pkg::CSR_METHOD, 9'd1));
      dir_rows.push_back(csr_row(rps_pkg::CSR_COUNT, 9'd2));
      dir_rows.push_back(fixed_row(rps_pkg::CMD_LOAD, 31'd0, 8'd0, rps_pkg::ST_LOADED,
                                   8'd0, 1'b0));
      dir_rows.push_back(item_row(rps_pkg::CMD_STEP, 31'd1, 8'd0));
      dir_rows.push_back(item_row(rps_pkg::CMD_STEP, 31'd0, 8'd0));
      dir_rows.push_back(item_row(rps_pkg::CMD_READ, 31'd0, 8'd1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         if (row.is_csr) begin
            wait_for_idle();
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            send_item(row.cmd, row.word, row.idx, row.typed, row.rsp);
         end
      end

      // back-pressure: results held off while items keep coming
      wait_for_idle();
      write_csr(rps_pkg::CSR_COUNT, 9'd24);
      send_random(rps_pkg::CMD_LOAD, 31'd0);
      hold_req = 1'b1;
      for (k = 0; k < 24; k++) begin
         if (k % 4 == 3) send_read();
         else send_random(rps_pkg::CMD_STEP, pick_word());
      end

      for (mode = 0; mode < 4; mode++) begin
         wait_for_idle();
         send_idle_pct = mode_send[mode];
         stall_pct     = mode_stall[mode];
         mark = results_sent;
         while (results_sent - mark < ITEMS_PER_MODE) run_shuffle_sequence();
      end

      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d results (%0d swaps, %0d rejected words) over %0d register writes,",
               results_seen, swaps_seen, rejects_seen, csr_writes);
      $display("both shuffle methods, clamped counts, reads and idle/stall mixes; %0d errors.",
               errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: random_permutation_shuffler.f
+incdir+src
src/rps_pkg.sv
src/rps_store.sv
src/rps_mod_unit.sv
src/random_permutation_shuffler.sv
dv/testbench.sv
